[hw/rtl/ialu_pkg.sv]
// Shared types and constants for the integer ALU.
package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 64;

    localparam logic [3:0] OP_POW = 4'd0;
    localparam logic [3:0] OP_MUL = 4'd1;
    localparam logic [3:0] OP_DIV = 4'd2;
    localparam logic [3:0] OP_MOD = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_SUB = 4'd5;
    localparam logic [3:0] OP_AND = 4'd6;
    localparam logic [3:0] OP_XOR = 4'd7;
    localparam logic [3:0] OP_OR  = 4'd8;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_POW_NEG = 2'd1;
    localparam logic [1:0] ERR_DIV0    = 2'd2;
    localparam logic [1:0] ERR_MOD0    = 2'd3;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [63:0] left_operand;
        logic signed [63:0] right_operand;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] result_value;
        logic [1:0]         error_code;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture operands, set up the operation
        logic step;      // one iteration of the shared loop
        logic mul_step;  // one partial product of the 64x64 multiplier
        logic finish;    // form the final result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic iterate;   // operation needs the iterative loop
        logic last;      // divide count, exponent or multiply done
        logic mul_busy;  // multiplier still accumulating
    } dp_stat_t;

endpackage

[hw/rtl/integer_alu_pow_div_mod.sv]
// Top level of the signed integer ALU.
// One operation is in flight at a time. Add, subtract, the logic ops, power
// with a zero or negative exponent and divide or remainder by zero go from
// the transfer in straight to the output register. Multiply runs four
// half-width partial products through one shared multiplier. Divide and
// remainder run a restoring radix-2 divider, one quotient bit a cycle.
// Power squares and multiplies through the same multiplier, one exponent
// bit at a time up to the top set bit, multiplying only where the bit is
// set, so for large exponents it dominates. The next transfer in is taken
// the cycle after the result is registered. A finished result waits in the
// output register while the next item is taken in; that item then holds in
// its last cycle until the waiting result is taken.
module integer_alu_pow_div_mod #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ialu_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ialu_pkg::out_item_t out_data
);
    ialu_pkg::dp_cmd_t  cmd;
    ialu_pkg::dp_stat_t stat;

    ialu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    ialu_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_item (out_data)
    );

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid && out_stall))
        else $error("result overwritten");

    // errors always carry a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != ialu_pkg::ERR_OK |->
        out_data.result_value == '0)
        else $error("error with nonzero value");

    // operand load and result capture are exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.finish))
        else $error("load and finish together");
endmodule

[hw/rtl/ialu_datapath.sv]
// Datapath of the integer ALU: operands, shared multiplier, divider and power loop.
module ialu_datapath #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ialu_pkg::in_item_t in_item,
    input  ialu_pkg::dp_cmd_t  cmd,
    output ialu_pkg::dp_stat_t stat,
    output ialu_pkg::out_item_t out_item
);
    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam int HW = (W + 1) / 2;   // multiplier half width

    logic [3:0]   op_reg;
    logic [W-1:0] a_reg, b_reg;
    logic [W-1:0] acc_reg, acc_next;     // power result / quotient
    logic [W-1:0] base_reg, base_next;   // power base / remainder
    logic [W-1:0] e_reg, e_next;         // exponent / dividend shifter
    logic [W-1:0] divisor_reg;
    logic         sign_q_reg, sign_r_reg;
    logic [CW-1:0] cnt_reg;

    // multiplier: four HWxHW partial products, one per cycle
    logic [W-1:0] mx_reg, my_reg, prod_reg;
    logic [1:0]   mph_reg;
    logic         mbusy_reg;
    logic [2*HW-1:0] mxe, mye;
    logic [HW-1:0] pa, pb;
    logic [2*HW-1:0] pp;
    logic [W-1:0]  pp_sh;
    logic          mul_start;
    logic [W-1:0]  ms_x, ms_y;
    // which product the power loop wants: 0 acc*base, 1 base*base
    logic          pow_phase_reg;

    assign mxe = (2*HW)'(mx_reg);
    assign mye = (2*HW)'(my_reg);
    always_comb
    begin
        pa = mph_reg[0] ? mxe[2*HW-1:HW] : mxe[HW-1:0];
        pb = mph_reg[1] ? mye[2*HW-1:HW] : mye[HW-1:0];
        pp = (2*HW)'(pa) * (2*HW)'(pb);
        case (mph_reg)
            2'd0: pp_sh = W'(pp);
            2'd1, 2'd2: pp_sh = W'({pp, {HW{1'b0}}});
            default: pp_sh = '0;   // high x high lands above W bits
        endcase
    end

    logic a_neg, b_neg;
    logic [W-1:0] ua, ub;
    assign a_neg = in_item.left_operand[W-1];
    assign b_neg = in_item.right_operand[W-1];
    assign ua = a_neg ? -in_item.left_operand[W-1:0] : in_item.left_operand[W-1:0];
    assign ub = b_neg ? -in_item.right_operand[W-1:0] : in_item.right_operand[W-1:0];

    logic is_pow_loop, is_div;
    assign is_div = (in_item.mode == ialu_pkg::OP_DIV || in_item.mode == ialu_pkg::OP_MOD)
                    && (in_item.right_operand[W-1:0] != '0);
    assign is_pow_loop = (in_item.mode == ialu_pkg::OP_POW)
                         && !b_neg && (in_item.right_operand[W-1:0] != '0);

    // restoring division step
    logic [W:0] trial;
    logic [W-1:0] rem_sh;
    assign rem_sh = {base_reg[W-2:0], e_reg[W-1]};
    assign trial  = {base_reg[W-1], rem_sh} - {1'b0, divisor_reg};

    logic op_is_div;
    assign op_is_div = (op_reg == ialu_pkg::OP_DIV || op_reg == ialu_pkg::OP_MOD);

    always_comb
    begin
        acc_next  = acc_reg;
        base_next = base_reg;
        e_next    = e_reg;
        mul_start = 1'b0;
        ms_x      = acc_reg;
        ms_y      = base_reg;
        if (cmd.step)
        begin
            if (op_is_div)
            begin
                e_next = {e_reg[W-2:0], 1'b0};
                if (!trial[W])
                begin
                    base_next = trial[W-1:0];
                    acc_next  = {acc_reg[W-2:0], 1'b1};
                end
                else
                begin
                    base_next = rem_sh;
                    acc_next  = {acc_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                mul_start = 1'b1;
                ms_x = pow_phase_reg ? base_reg : acc_reg;
                ms_y = base_reg;
            end
        end
        else if (cmd.load)
        begin
            if (is_div)
            begin
                acc_next  = '0;
                base_next = '0;
                e_next    = ua;
            end
            else
            begin
                acc_next  = W'(1);
                base_next = in_item.left_operand[W-1:0];
                e_next    = in_item.right_operand[W-1:0];
            end
            if (in_item.mode == ialu_pkg::OP_MUL)
            begin
                mul_start = 1'b1;
                ms_x = in_item.left_operand[W-1:0];
                ms_y = in_item.right_operand[W-1:0];
            end
        end
        // power loop: fold multiplier result back when it completes
        if (cmd.mul_step && mbusy_reg && mph_reg == 2'd3 && op_reg == ialu_pkg::OP_POW)
        begin
            if (pow_phase_reg)
            begin
                base_next = prod_reg + pp_sh;
                e_next    = e_reg >> 1;
            end
            else
            begin
                acc_next = prod_reg + pp_sh;
            end
        end
    end

    // power sequencing: phase 0 multiplies acc*base when e[0], phase 1 squares
    logic pow_done_phase;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg     <= 1'b0;
            mph_reg       <= 2'd0;
            pow_phase_reg <= 1'b0;
        end
        else
        begin
            if (mul_start && !(op_reg == ialu_pkg::OP_POW && cmd.step && !pow_phase_reg
                               && !e_reg[0]))
            begin
                mbusy_reg <= 1'b1;
                mph_reg   <= 2'd0;
            end
            else if (cmd.mul_step && mbusy_reg)
            begin
                mph_reg <= mph_reg + 2'd1;
                if (mph_reg == 2'd3)
                    mbusy_reg <= 1'b0;
            end
            if (cmd.load)
                pow_phase_reg <= 1'b0;
            else if (pow_done_phase)
                pow_phase_reg <= !pow_phase_reg;
        end
    end
    // a power phase ends when its product folds in, or at once when skipped
    assign pow_done_phase = (op_reg == ialu_pkg::OP_POW) &&
        ((cmd.mul_step && mbusy_reg && mph_reg == 2'd3) ||
         (cmd.step && !pow_phase_reg && !e_reg[0]));

    always_ff @(posedge clk)
    begin
        if (mul_start)
        begin
            mx_reg   <= ms_x;
            my_reg   <= ms_y;
            prod_reg <= '0;
        end
        else if (cmd.mul_step && mbusy_reg)
        begin
            prod_reg <= prod_reg + pp_sh;
        end
        acc_reg  <= acc_next;
        base_reg <= base_next;
        e_reg    <= e_next;
        if (cmd.load)
        begin
            op_reg      <= in_item.mode;
            a_reg       <= in_item.left_operand[W-1:0];
            b_reg       <= in_item.right_operand[W-1:0];
            sign_q_reg  <= a_neg ^ b_neg;
            sign_r_reg  <= a_neg;
            divisor_reg <= ub;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load)
            cnt_reg <= '0;
        else if (cmd.step && op_is_div)
            cnt_reg <= cnt_reg + CW'(1);
    end

    assign stat.iterate  = is_div || is_pow_loop || (in_item.mode == ialu_pkg::OP_MUL);
    assign stat.last     = op_is_div ? (cnt_reg == CW'(W))
                         : (op_reg == ialu_pkg::OP_POW ? (e_reg == '0 && !pow_phase_reg)
                         : !mbusy_reg);
    assign stat.mul_busy = mbusy_reg;

    // final result
    logic [W-1:0] r;
    logic [1:0]   err;
    always_comb
    begin
        r   = '0;
        err = ialu_pkg::ERR_OK;
        case (op_reg)
            ialu_pkg::OP_POW:
            begin
                if (b_reg == '0)
                    r = a_reg[W-1] ? '1 : W'(1);
                else if (b_reg[W-1])
                begin
                    if (a_reg == '0)
                        err = ialu_pkg::ERR_POW_NEG;
                    else if (a_reg == W'(1) || a_reg == '1)
                        r = a_reg;
                end
                else
                    r = acc_reg;
            end
            ialu_pkg::OP_MUL: r = prod_reg;
            ialu_pkg::OP_DIV:
            begin
                if (b_reg == '0) err = ialu_pkg::ERR_DIV0;
                else r = sign_q_reg ? -acc_reg : acc_reg;
            end
            ialu_pkg::OP_MOD:
            begin
                if (b_reg == '0) err = ialu_pkg::ERR_MOD0;
                else r = sign_r_reg ? -base_reg : base_reg;
            end
            ialu_pkg::OP_ADD: r = a_reg + b_reg;
            ialu_pkg::OP_SUB: r = a_reg - b_reg;
            ialu_pkg::OP_AND: r = a_reg & b_reg;
            ialu_pkg::OP_XOR: r = a_reg ^ b_reg;
            ialu_pkg::OP_OR:  r = a_reg | b_reg;
            default: r = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_item.result_value <= 64'(signed'(r));
            out_item.error_code   <= err;
        end
    end
endmodule

[hw/rtl/ialu_ctrl.sv]
// Controller state machine of the integer ALU.
module ialu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  ialu_pkg::dp_stat_t stat,
    output ialu_pkg::dp_cmd_t  cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       accept;

    // accept while idle; a waiting result is parted by the output register
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next   = state_reg;
        ov_next      = ov_reg && out_stall;
        cmd.load     = accept;
        cmd.step     = 1'b0;
        cmd.mul_step = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = stat.iterate ? S_RUN : S_FIN;
            end
            S_RUN:
            begin
                if (stat.mul_busy)
                    cmd.mul_step = 1'b1;
                else if (stat.last)
                    state_next = S_FIN;
                else
                    cmd.step = 1'b1;
            end
            S_FIN:
            begin
                if (!ov_next)
                begin
                    cmd.finish = 1'b1;
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

[sim/integer_alu_pow_div_mod_test.sv]
// Testbench for the signed integer ALU: directed and random operations checked against a predictor.
`timescale 1ns / 1ps

module integer_alu_pow_div_mod_test;

    localparam int NUM_RANDOM = 1800;
    localparam longint CYCLE_LIMIT = 8000000;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    ialu_pkg::in_item_t  in_data;
    logic                out_valid;
    logic                out_stall;
    ialu_pkg::out_item_t out_data;

    // Expected results, oldest first
    ialu_pkg::out_item_t pending_results[$];
    int          mismatch_count;
    int          unexpected_count;
    longint      cycle_count;
    bit          sender_idle_enable;
    bit          receiver_stall_enable;

    integer_alu_pow_div_mod dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Predicted ALU result for one operation, 64-bit wrapping arithmetic
    function automatic ialu_pkg::out_item_t alu_predict(ialu_pkg::in_item_t op);
        ialu_pkg::out_item_t res;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] base;
        logic [63:0] e;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [1:0]  err;
        a   = op.left_operand;
        b   = op.right_operand;
        r   = '0;
        err = ialu_pkg::ERR_OK;
        case (op.mode)
            ialu_pkg::OP_POW:
            begin
                if (b == 0)
                    r = a[63] ? '1 : 64'd1;
                else if (b[63])
                begin
                    if (a == 0)
                        err = ialu_pkg::ERR_POW_NEG;
                    else if (a == 64'd1 || a == '1)
                        r = a;
                end
                else
                begin
                    base = a;
                    e    = b;
                    r    = 64'd1;
                    while (e != 0)
                    begin
                        if (e[0])
                            r = r * base;
                        e    = e >> 1;
                        base = base * base;
                    end
                end
            end
            ialu_pkg::OP_MUL: r = a * b;
            ialu_pkg::OP_DIV, ialu_pkg::OP_MOD:
            begin
                if (b == 0)
                    err = (op.mode == ialu_pkg::OP_DIV) ? ialu_pkg::ERR_DIV0
                                                        : ialu_pkg::ERR_MOD0;
                else
                begin
                    ua = a[63] ? -a : a;
                    ub = b[63] ? -b : b;
                    if (op.mode == ialu_pkg::OP_DIV)
                        r = (a[63] != b[63]) ? -(ua / ub) : ua / ub;
                    else
                        r = a[63] ? -(ua % ub) : ua % ub;
                end
            end
            ialu_pkg::OP_ADD: r = a + b;
            ialu_pkg::OP_SUB: r = a - b;
            ialu_pkg::OP_AND: r = a & b;
            ialu_pkg::OP_XOR: r = a ^ b;
            ialu_pkg::OP_OR:  r = a | b;
            default: r = '0;
        endcase
        if (err != ialu_pkg::ERR_OK)
            r = '0;
        res.result_value = r;
        res.error_code   = err;
        return res;
    endfunction

    // Random operand biased towards edges and small values
    function automatic logic [63:0] pick_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = 64'h8000_0000_0000_0000;
            1: v = 64'h7FFF_FFFF_FFFF_FFFF;
            2: v = '1;
            3: v = '0;
            4: v = 64'd1;
            5, 6: v = 64'($signed($urandom_range(0, 40)) - 20);
            7: v = v >> $urandom_range(0, 63);
            default: ;
        endcase
        return v;
    endfunction

    // Send one operation; holds the payload until the transfer
    task automatic send_op(logic [3:0] mode, logic [63:0] lhs, logic [63:0] rhs);
        ialu_pkg::in_item_t item;
        int       gap;
        item.mode          = mode;
        item.left_operand  = lhs;
        item.right_operand = rhs;
        if (sender_idle_enable && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        pending_results.push_back(alu_predict(item));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    // Receiver stall bursts
    initial
    begin
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (receiver_stall_enable && $urandom_range(0, 7) == 0)
            begin
                burst = $urandom_range(1, 19);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Result checker: compares each transfer out with the oldest prediction
    always @(posedge clk)
    begin
        ialu_pkg::out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected result %h err %0d", out_data.result_value,
                             out_data.error_code);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.result_value !== out_data.result_value
                    || want.error_code !== out_data.error_code)
                begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display("mismatch: want %h/%0d got %h/%0d",
                                 want.result_value, want.error_code,
                                 out_data.result_value, out_data.error_code);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Directed: multiply, add, subtract and logic opcodes at the field extremes, plus two undefined opcodes
    task automatic test_basic_ops();
        logic [63:0] mn;
        logic [63:0] mx;
        mn = 64'h8000_0000_0000_0000;
        mx = 64'h7FFF_FFFF_FFFF_FFFF;
        send_op(ialu_pkg::OP_MUL, mx, mx);
        send_op(ialu_pkg::OP_MUL, mn, '1);
        send_op(ialu_pkg::OP_ADD, mx, 64'd1);
        send_op(ialu_pkg::OP_SUB, mn, 64'd1);
        send_op(ialu_pkg::OP_AND, '1, 64'h5555_AAAA_0F0F_F0F0);
        send_op(ialu_pkg::OP_XOR, '1, mn);
        send_op(ialu_pkg::OP_OR,  mn, 64'd0);
        send_op(4'd9,  mx, mx);
        send_op(4'd15, '1, '1);
    endtask

    // Directed: zero and negative exponents, large powers
    task automatic test_power_cases();
        send_op(ialu_pkg::OP_POW, 64'd0, 64'd0);
        send_op(ialu_pkg::OP_POW, -64'sd7, 64'd0);
        send_op(ialu_pkg::OP_POW, 64'd0, -64'sd3);
        send_op(ialu_pkg::OP_POW, 64'd1, -64'sd5);
        send_op(ialu_pkg::OP_POW, '1, 64'h8000_0000_0000_0000);
        send_op(ialu_pkg::OP_POW, 64'h8000_0000_0000_0000, '1);
        send_op(ialu_pkg::OP_POW, 64'd3, 64'h7FFF_FFFF_FFFF_FFFF);
        send_op(ialu_pkg::OP_POW, -64'sd2, 64'd63);
    endtask

    // Directed: divide by zero, most negative over minus one and mixed-sign operands
    task automatic test_division_cases();
        send_op(ialu_pkg::OP_DIV, 64'd5, 64'd0);
        send_op(ialu_pkg::OP_MOD, 64'd5, 64'd0);
        send_op(ialu_pkg::OP_DIV, 64'h8000_0000_0000_0000, '1);
        send_op(ialu_pkg::OP_MOD, 64'h8000_0000_0000_0000, '1);
        send_op(ialu_pkg::OP_DIV, -64'sd7, 64'd2);
        send_op(ialu_pkg::OP_MOD, -64'sd7, 64'd2);
        send_op(ialu_pkg::OP_DIV, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    endtask

    // Random operations; small exponents mostly so power stays quick
    task automatic test_random_ops(int count);
        logic [3:0]  mode;
        logic [63:0] rhs;
        for (int i = 0; i < count; i++)
        begin
            mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
            rhs  = pick_operand();
            if (mode == ialu_pkg::OP_POW && !rhs[63] && $urandom_range(0, 3) != 0)
                rhs = 64'($urandom_range(0, 70));
            send_op(mode, pick_operand(), rhs);
        end
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        in_valid              = 1'b0;
        in_data               = '0;
        mismatch_count        = 0;
        unexpected_count      = 0;
        cycle_count           = 0;
        sender_idle_enable    = 1'b1;
        receiver_stall_enable = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_power_cases();
        test_division_cases();
        test_random_ops(NUM_RANDOM - 200);
        // Final stretch runs flat out on both sides
        sender_idle_enable    = 1'b0;
        receiver_stall_enable = 1'b0;
        test_random_ops(200);
        drop_valid();

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatch_count == 0 && unexpected_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
